// ===== hw/rtl/dtm_pkg.sv =====
package dtm_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 63;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int CH_W    = 4;
  localparam int OVF_W   = 8;
  localparam int TIME_W  = 64;
  localparam int MASK_W  = 8;
  localparam int DELAY_W = 31;
  localparam int ENTRY_W = CH_W + TIME_W;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = DELAY_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MASK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_AMOUNT = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [MASK_W-1:0]  MASK_RESET  = MASK_W'(1);
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(54000);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ
  } dtm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic push;
    logic rd_en;
    logic pop;
    logic emit_head;
    logic emit_last;
    logic emit_own;
    logic own_drop;
  } dtm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_flush;
    logic matched;
    logic empty;
    logic full;
    logic one_left;
    logic head_le;
    logic out_free;
  } dtm_sts_t;

  // Ring index advance with wrap at the queue depth
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    return r;
  endfunction

endpackage

// ===== hw/rtl/dtm_in_if.sv =====
interface dtm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [dtm_pkg::CH_W-1:0]    tag_channel;
  logic [dtm_pkg::OVF_W-1:0]   tag_overflow;
  logic [dtm_pkg::TIME_W-1:0]  tag_time;

  modport source (output valid, command, tag_channel, tag_overflow, tag_time,
                  input ready);
  modport sink   (input valid, command, tag_channel, tag_overflow, tag_time,
                  output ready);
endinterface

// ===== hw/rtl/dtm_out_if.sv =====
interface dtm_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtm_pkg::OVF_W-1:0]   out_overflow;
  logic [dtm_pkg::CH_W-1:0]    out_channel;
  logic [dtm_pkg::TIME_W-1:0]  out_time;
  logic                        dropped;
  logic                        last;

  modport source (output valid, out_overflow, out_channel, out_time, dropped, last,
                  input ready);
  modport sink   (input valid, out_overflow, out_channel, out_time, dropped, last,
                  output ready);
endinterface

// ===== hw/rtl/dtm_cfg_if.sv =====
interface dtm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dtm_pkg::CFG_IDX_W-1:0]   index;
  logic [dtm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dtm_ram.sv =====
module dtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dtm_ctrl.sv =====
module dtm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtm_pkg::dtm_sts_t sts,
  output dtm_pkg::dtm_cmd_t cmd
);

  dtm_pkg::dtm_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dtm_pkg::ST_DISPATCH;
      end
      dtm_pkg::ST_DISPATCH: begin
        if (sts.is_flush) begin
          state_nxt = sts.empty ? dtm_pkg::ST_IDLE : dtm_pkg::ST_READ;
        end else if (sts.matched) begin
          if (!sts.full || sts.out_free) state_nxt = dtm_pkg::ST_IDLE;
        end else if (sts.empty) begin
          if (sts.out_free) state_nxt = dtm_pkg::ST_IDLE;
        end else begin
          state_nxt = dtm_pkg::ST_READ;
        end
      end
      dtm_pkg::ST_READ: begin
        if (sts.out_free) begin
          if (sts.is_flush) begin
            if (sts.one_left) state_nxt = dtm_pkg::ST_IDLE;
          end else if (sts.head_le) begin
            // last release: the tag itself follows from dispatch
            if (sts.one_left) state_nxt = dtm_pkg::ST_DISPATCH;
          end else begin
            state_nxt = dtm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = dtm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      dtm_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      dtm_pkg::ST_DISPATCH: begin
        if (sts.is_flush) begin
          cmd.rd_en = !sts.empty;
        end else if (sts.matched) begin
          if (!sts.full) begin
            cmd.push = 1'b1;
          end else if (sts.out_free) begin
            cmd.emit_own = 1'b1;
            cmd.own_drop = 1'b1;
          end
        end else if (sts.empty) begin
          cmd.emit_own = sts.out_free;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      dtm_pkg::ST_READ: begin
        if (sts.out_free) begin
          if (sts.is_flush || sts.head_le) begin
            cmd.emit_head = 1'b1;
            cmd.emit_last = sts.is_flush && sts.one_left;
            cmd.pop       = 1'b1;
            cmd.rd_en     = !sts.one_left;
          end else begin
            cmd.emit_own = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dtm_datapath.sv =====
module dtm_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beat payload
  input  logic                               command,
  input  logic [dtm_pkg::CH_W-1:0]           tag_channel,
  input  logic [dtm_pkg::OVF_W-1:0]          tag_overflow,
  input  logic [dtm_pkg::TIME_W-1:0]         tag_time,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // control
  input  dtm_pkg::dtm_cmd_t                  cmd,
  output dtm_pkg::dtm_sts_t                  sts,
  // result register
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dtm_pkg::OVF_W-1:0]          out_overflow,
  output logic [dtm_pkg::CH_W-1:0]           out_channel,
  output logic [dtm_pkg::TIME_W-1:0]         out_time,
  output logic                               dropped,
  output logic                               last
);

  logic [dtm_pkg::MASK_W-1:0]  mask_r;
  logic [dtm_pkg::DELAY_W-1:0] delay_r;

  logic                        cmd_r;
  logic [dtm_pkg::CH_W-1:0]    ch_r;
  logic [dtm_pkg::OVF_W-1:0]   ovf_r;
  logic [dtm_pkg::TIME_W-1:0]  time_r;

  logic [dtm_pkg::IDX_W-1:0]   wr_idx_r, rd_idx_r;
  logic [dtm_pkg::CNT_W-1:0]   count_r;

  logic                        out_valid_r;
  logic [dtm_pkg::OVF_W-1:0]   out_ovf_r;
  logic [dtm_pkg::CH_W-1:0]    out_ch_r;
  logic [dtm_pkg::TIME_W-1:0]  out_time_r;
  logic                        out_drop_r;
  logic                        out_last_r;

  logic [dtm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [dtm_pkg::IDX_W-1:0]   ram_raddr;
  logic [dtm_pkg::TIME_W-1:0]  head_time;
  logic [dtm_pkg::CH_W-1:0]    head_ch;
  logic [2:0]                  mask_bit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= dtm_pkg::MASK_RESET;
      delay_r <= dtm_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dtm_pkg::CFG_MATCH_MASK) begin
        mask_r <= cfg_data[dtm_pkg::MASK_W-1:0];
      end else if (cfg_index == dtm_pkg::CFG_DELAY_AMOUNT) begin
        delay_r <= cfg_data;
      end
    end
  end

  // Captured input beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= command;
      ch_r   <= tag_channel;
      ovf_r  <= tag_overflow;
      time_r <= tag_time;
    end
  end

  // Ring pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      if (cmd.push) begin
        wr_idx_r <= dtm_pkg::idx_inc(wr_idx_r);
        count_r  <= count_r + 1'b1;
      end else if (cmd.pop) begin
        rd_idx_r <= dtm_pkg::idx_inc(rd_idx_r);
        count_r  <= count_r - 1'b1;
      end
    end
  end

  // Queue storage: {channel, delayed time}
  assign ram_wdata = {ch_r, time_r + {{(dtm_pkg::TIME_W - dtm_pkg::DELAY_W){1'b0}}, delay_r}};
  // a pop reads ahead to the entry after the current head
  assign ram_raddr = cmd.pop ? dtm_pkg::idx_inc(rd_idx_r) : rd_idx_r;

  dtm_ram #(
    .WIDTH (dtm_pkg::ENTRY_W),
    .DEPTH (dtm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign head_time = ram_rdata[dtm_pkg::TIME_W-1:0];
  assign head_ch   = ram_rdata[dtm_pkg::ENTRY_W-1:dtm_pkg::TIME_W];

  // Status toward the controller
  assign mask_bit     = 3'(ch_r - 4'd1);
  assign sts.is_flush = cmd_r;
  assign sts.matched  = (ch_r != '0) && (ch_r <= 4'd8) && mask_r[mask_bit];
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == dtm_pkg::CNT_W'(dtm_pkg::QUEUE_DEPTH));
  assign sts.one_left = (count_r == dtm_pkg::CNT_W'(1));
  assign sts.head_le  = (head_time <= time_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_head || cmd.emit_own) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_head) begin
      out_ovf_r  <= '0;
      out_ch_r   <= head_ch;
      out_time_r <= head_time;
      out_drop_r <= 1'b0;
      out_last_r <= cmd.emit_last;
    end else if (cmd.emit_own) begin
      out_ovf_r  <= ovf_r;
      out_ch_r   <= ch_r;
      out_time_r <= time_r;
      out_drop_r <= cmd.own_drop;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_overflow = out_ovf_r;
  assign out_channel  = out_ch_r;
  assign out_time     = out_time_r;
  assign dropped      = out_drop_r;
  assign last         = out_last_r;

endmodule

// ===== hw/rtl/delayed_timetag_merger.sv =====
// Delayed time tag merger.
// in_ch carries one time tag or a flush command per beat. Tags on channels
// selected by match_mask are delayed by delay_amount and held in a 63-entry
// ring, or come out with dropped set when the ring is full; other tags
// release every queued tag due at or before their time, oldest first, and
// then come out themselves (last set on the final beat). A flush releases
// every queued tag. cfg_ch writes match_mask (index 0) or delay_amount
// (index 1); it is always ready and should be used only while the block is
// idle. Handshake: in_ch.ready is high in idle only, so one item is worked
// at a time. A queued tag, or any tag while the ring is empty, is finished
// in the dispatch state, where a prompt tag's own beat is loaded. With tags
// queued, the ring head is read first; the due tags are then loaded oldest
// first, then the tag itself, and then the input is ready again.
// The output register lets the next tag be accepted while a result waits.
// When out_ch.ready is low the sequencer holds its place and no beat is lost.
// Reset (rst_n low, synchronous) empties the ring, clears out_ch.valid and
// restores match_mask = 1 and delay_amount = 54000.
module delayed_timetag_merger (
  input  logic  clk,
  input  logic  rst_n,
  dtm_in_if.sink    in_ch,
  dtm_out_if.source out_ch,
  dtm_cfg_if.sink   cfg_ch
);

  dtm_pkg::dtm_cmd_t cmd;
  dtm_pkg::dtm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtm_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .command      (in_ch.command),
    .tag_channel  (in_ch.tag_channel),
    .tag_overflow (in_ch.tag_overflow),
    .tag_time     (in_ch.tag_time),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_overflow (out_ch.out_overflow),
    .out_channel  (out_ch.out_channel),
    .out_time     (out_ch.out_time),
    .dropped      (out_ch.dropped),
    .last         (out_ch.last)
  );

  // A result is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_head || cmd.emit_own) |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // Never push into a full ring
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push into full queue");

  // Never pop an empty ring
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.empty)
    else $error("pop from empty queue");

  // An accepted beat blocks the input for at least the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while busy");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // Widths and codes shared with the design
  localparam int QUEUE_DEPTH = dtm_pkg::QUEUE_DEPTH;
  localparam int CH_W        = dtm_pkg::CH_W;
  localparam int OVF_W       = dtm_pkg::OVF_W;
  localparam int TIME_W      = dtm_pkg::TIME_W;
  localparam int MASK_W      = dtm_pkg::MASK_W;
  localparam int DELAY_W     = dtm_pkg::DELAY_W;
  localparam int CFG_IDX_W   = dtm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = dtm_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MASK   = dtm_pkg::CFG_MATCH_MASK;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_AMOUNT = dtm_pkg::CFG_DELAY_AMOUNT;
  localparam logic [MASK_W-1:0]    MASK_RESET       = dtm_pkg::MASK_RESET;
  localparam logic [DELAY_W-1:0]   DELAY_RESET      = dtm_pkg::DELAY_RESET;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int IDLE_PCT      = 23;
  localparam int PHASE_TAGS    = 67;
  localparam int N_ROWS        = 18;

  localparam logic CMD_TAG   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MID  = CFG_IDX_W'(8'h80);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = CFG_IDX_W'(8'hFF);

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  typedef struct packed {
    logic [OVF_W-1:0]  ovf;
    logic [CH_W-1:0]   chan;
    logic [TIME_W-1:0] tstamp;
    logic              drop;
    logic              last;
  } tag_beat_t;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_ONE
  } row_exp_t;

  typedef struct packed {
    logic              cmd;
    logic [CH_W-1:0]   chan;
    logic [OVF_W-1:0]  ovf;
    logic [TIME_W-1:0] tstamp;
    row_exp_t          kind;
    tag_beat_t         beat;
  } tag_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dtm_in_if  in_ch ();
  dtm_out_if out_ch ();
  dtm_cfg_if cfg_ch ();

  delayed_timetag_merger dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Shadow of the delay ring and registers
  logic [TIME_W-1:0]  ring_time [QUEUE_DEPTH];
  logic [CH_W-1:0]    ring_chan [QUEUE_DEPTH];
  int                 ring_wr   = 0;
  int                 ring_rd   = 0;
  int                 ring_fill = 0;
  logic [MASK_W-1:0]  cur_mask  = MASK_RESET;
  logic [DELAY_W-1:0] cur_delay = DELAY_RESET;

  tag_beat_t pending_beats [$];
  tag_beat_t step_beats [$];

  tag_row_t dir_rows [N_ROWS];

  int  fail_count    = 0;
  int  items_sent    = 0;
  int  flush_count   = 0;
  int  beats_seen    = 0;
  int  release_count = 0;
  int  drop_count    = 0;
  int  setting_count = 1;
  int  cycle_count   = 0;
  int  hold_left     = 0;
  bit  hold_arm      = 1'b0;
  bit  no_idle       = 1'b0;

  function automatic bit is_delayed(input logic [CH_W-1:0] ch);
    return (ch >= 1 && ch <= MASK_W) && cur_mask[ch - 1'b1];
  endfunction

  function automatic tag_beat_t one_beat(input logic [OVF_W-1:0] ovf,
                                         input logic [CH_W-1:0] ch,
                                         input logic [TIME_W-1:0] stamp);
    return '{ovf, ch, stamp, 1'b0, 1'b1};
  endfunction

  // Pop the ring head into the current item's beats
  function automatic void release_head();
    step_beats.push_back('{OVF_W'(0), ring_chan[ring_rd], ring_time[ring_rd], 1'b0, 1'b0});
    ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
    ring_fill--;
    release_count++;
  endfunction

  // Beats one accepted item causes, ring updated in place
  function automatic void merge_tag(input logic cmd, input logic [CH_W-1:0] ch,
                                    input logic [OVF_W-1:0] ovf,
                                    input logic [TIME_W-1:0] stamp);
    tag_beat_t b;
    step_beats.delete();
    if (cmd == CMD_FLUSH) begin
      while (ring_fill > 0) release_head();
    end else if (is_delayed(ch)) begin
      if (ring_fill >= QUEUE_DEPTH) begin
        step_beats.push_back('{ovf, ch, stamp, 1'b1, 1'b0});
        drop_count++;
      end else begin
        ring_time[ring_wr] = stamp + TIME_W'(cur_delay);
        ring_chan[ring_wr] = ch;
        ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
        ring_fill++;
      end
    end else begin
      while (ring_fill > 0 && ring_time[ring_rd] <= stamp) release_head();
      step_beats.push_back('{ovf, ch, stamp, 1'b0, 1'b0});
    end
    if (step_beats.size() > 0) begin
      b = step_beats.pop_back();
      b.last = 1'b1;
      step_beats.push_back(b);
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [CH_W-1:0] ch,
                           input logic [OVF_W-1:0] ovf, input logic [TIME_W-1:0] stamp,
                           input row_exp_t kind, input tag_beat_t typed);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.tag_channel  <= ch;
    in_ch.tag_overflow <= ovf;
    in_ch.tag_time     <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    merge_tag(cmd, ch, ovf, stamp);
    items_sent++;
    if (cmd == CMD_FLUSH) flush_count++;
    case (kind)
      EXP_MODEL: foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
      EXP_ONE:   pending_beats.push_back(typed);
      default:   ;
    endcase
  endtask

  // Block idle: every beat out, queued tags settled
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_MATCH_MASK) cur_mask = word[MASK_W-1:0];
    else if (idx == CFG_DELAY_AMOUNT) cur_delay = word[DELAY_W-1:0];
  endtask

  // Mask goes out with junk in the upper data bits; one ignored index too
  task automatic set_config(input logic [MASK_W-1:0] mask, input logic [DELAY_W-1:0] delay,
                            input logic [CFG_IDX_W-1:0] spare_idx);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    word = CFG_DATA_W'($urandom);
    word[MASK_W-1:0] = mask;
    write_reg(CFG_MATCH_MASK, word);
    write_reg(CFG_DELAY_AMOUNT, delay);
    write_reg(spare_idx, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [CH_W-1:0] pick_channel(input bit want_delayed);
    logic [CH_W-1:0] c;
    c = CH_W'(1);
    for (int tries = 0; tries < 16; tries++) begin
      c = CH_W'($urandom_range(MASK_W, 1));
      if (is_delayed(c) == want_delayed) return c;
    end
    return want_delayed ? c : CH_W'($urandom_range(15, MASK_W + 1));
  endfunction

  // Mostly rising time stamps with a mix of delayed and prompt tags
  task automatic random_phase(input int n_tags, input int delayed_pct);
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] t;
    logic [CH_W-1:0]   ch;
    int                roll;
    stamp = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                     : TIME_W'($urandom_range(5000));
    for (int i = 0; i < n_tags; i++) begin
      roll  = $urandom_range(99);
      stamp = stamp + TIME_W'($urandom_range(cur_delay / 3 + 40, 0));
      if (roll < 3) begin
        send_item(CMD_FLUSH, CH_W'($urandom), OVF_W'($urandom), {$urandom, $urandom},
                  EXP_MODEL, '0);
      end else if (roll < 8) begin
        send_item(CMD_TAG, CH_W'($urandom), OVF_W'($urandom), {$urandom, $urandom},
                  EXP_MODEL, '0);
      end else begin
        ch = pick_channel($urandom_range(99) < delayed_pct);
        t  = stamp;
        // land exactly on the head's release time now and then
        if (!is_delayed(ch) && ring_fill > 0 && $urandom_range(9) == 0)
          t = ring_time[ring_rd];
        send_item(CMD_TAG, ch, OVF_W'($urandom), t, EXP_MODEL, '0);
      end
    end
    send_item(CMD_FLUSH, CH_W'($urandom), OVF_W'($urandom), {$urandom, $urandom},
              EXP_MODEL, '0);
  endtask

  task automatic check_beat();
    tag_beat_t seen;
    tag_beat_t want;
    seen = '{out_ch.out_overflow, out_ch.out_channel, out_ch.out_time,
             out_ch.dropped, out_ch.last};
    beats_seen++;
    if (pending_beats.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected beat ovf=%h ch=%0d time=%h drop=%b last=%b", $realtime,
                 seen.ovf, seen.chan, seen.tstamp, seen.drop, seen.last);
    end else begin
      want = pending_beats.pop_front();
      if (seen.ovf !== want.ovf || seen.chan !== want.chan || seen.tstamp !== want.tstamp ||
          seen.drop !== want.drop || seen.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: beat mismatch exp ovf=%h ch=%0d time=%h drop=%b last=%b",
                   $realtime, want.ovf, want.chan, want.tstamp, want.drop, want.last);
          $display("    got ovf=%h ch=%0d time=%h drop=%b last=%b",
                   seen.ovf, seen.chan, seen.tstamp, seen.drop, seen.last);
        end
      end
    end
  endtask

  // Result side: check each beat, then pick next ready
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) check_beat();
    if (hold_arm) begin
      hold_left = LONG_HOLD;
      hold_arm  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_TAG;
    in_ch.tag_channel  = '0;
    in_ch.tag_overflow = '0;
    in_ch.tag_time     = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_MATCH_MASK;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;

    // Directed rows, reset registers: channel 1 delayed by 54000
    dir_rows[0]  = '{CMD_TAG, 4'd2, 8'hFF, 64'd0, EXP_ONE, one_beat(8'hFF, 4'd2, 64'd0)};
    dir_rows[1]  = '{CMD_TAG, 4'd1, 8'h12, 64'd100, EXP_NONE, '0};
    dir_rows[2]  = '{CMD_TAG, 4'd3, 8'h00, 64'd54099, EXP_ONE,
                     one_beat(8'h00, 4'd3, 64'd54099)};
    dir_rows[3]  = '{CMD_TAG, 4'd4, 8'h5A, 64'd54100, EXP_MODEL, '0};
    dir_rows[4]  = '{CMD_TAG, 4'd0, 8'hAA, TIME_MAX, EXP_ONE, one_beat(8'hAA, 4'd0, TIME_MAX)};
    dir_rows[5]  = '{CMD_TAG, 4'd15, 8'h01, 64'd5, EXP_ONE, one_beat(8'h01, 4'd15, 64'd5)};
    dir_rows[6]  = '{CMD_TAG, 4'd9, 8'h80, 64'h8000_0000_0000_0000, EXP_ONE,
                     one_beat(8'h80, 4'd9, 64'h8000_0000_0000_0000)};
    // flush with nothing queued
    dir_rows[7]  = '{CMD_FLUSH, 4'd1, 8'h33, 64'd0, EXP_NONE, '0};
    // delayed time wraps past the top of the range
    dir_rows[8]  = '{CMD_TAG, 4'd1, 8'h77, TIME_MAX, EXP_NONE, '0};
    dir_rows[9]  = '{CMD_TAG, 4'd1, 8'h00, 64'd0, EXP_NONE, '0};
    dir_rows[10] = '{CMD_TAG, 4'd8, 8'h01, 64'd53999, EXP_MODEL, '0};
    dir_rows[11] = '{CMD_FLUSH, 4'd1, 8'hFF, TIME_MAX, EXP_MODEL, '0};
    dir_rows[12] = '{CMD_TAG, 4'd1, 8'hC0, 64'd10, EXP_NONE, '0};
    dir_rows[13] = '{CMD_TAG, 4'd1, 8'h0C, 64'd20, EXP_NONE, '0};
    dir_rows[14] = '{CMD_TAG, 4'd2, 8'h3C, 64'd54015, EXP_MODEL, '0};
    dir_rows[15] = '{CMD_TAG, 4'd6, 8'h00, TIME_MAX - 1, EXP_MODEL, '0};
    dir_rows[16] = '{CMD_TAG, 4'd1, 8'h55, 64'h5555_5555_5555_5555, EXP_NONE, '0};
    dir_rows[17] = '{CMD_TAG, 4'd7, 8'hC3, 64'hAAAA_AAAA_AAAA_AAAA, EXP_MODEL, '0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++)
      send_item(dir_rows[r].cmd, dir_rows[r].chan, dir_rows[r].ovf, dir_rows[r].tstamp,
                dir_rows[r].kind, dir_rows[r].beat);

    // Fill the ring, overflow it, then release all of it under a stalled receiver
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_item(CMD_TAG, 4'd1, OVF_W'($urandom), TIME_W'(i * 10), EXP_MODEL, '0);
    hold_arm = 1'b1;
    send_item(CMD_TAG, 4'd2, OVF_W'($urandom), TIME_MAX, EXP_MODEL, '0);
    for (int i = 0; i < 6; i++)
      send_item(CMD_TAG, 4'd3, OVF_W'($urandom), TIME_MAX - TIME_W'(i), EXP_MODEL, '0);

    // Random phases over several register settings
    set_config(8'hFE, '0, CFG_SPARE_LOW);
    random_phase(PHASE_TAGS, 50);
    set_config(8'hFF, DELAY_MAX, CFG_SPARE_MID);
    random_phase(PHASE_TAGS, 90);
    set_config(8'h00, DELAY_W'(1), CFG_SPARE_HIGH);
    random_phase(PHASE_TAGS, 50);
    set_config(8'h55, DELAY_W'(1000), CFG_SPARE_LOW);
    no_idle = 1'b1;
    random_phase(PHASE_TAGS, 60);
    no_idle = 1'b0;
    set_config(MASK_W'($urandom), DELAY_W'($urandom), CFG_SPARE_HIGH);
    random_phase(PHASE_TAGS, 50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      fail_count++;
      $display("%0d expected beats never arrived", pending_beats.size());
    end

    $display("Run: %0d items incl. %0d flushes over %0d register settings, %0d beats checked",
             items_sent, flush_count, setting_count, beats_seen);
    $display("     %0d tags released from the delay ring, %0d dropped on a full ring",
             release_count, drop_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== delayed_timetag_merger.f =====
hw/rtl/dtm_pkg.sv
hw/rtl/dtm_in_if.sv
hw/rtl/dtm_out_if.sv
hw/rtl/dtm_cfg_if.sv
hw/rtl/dtm_ram.sv
hw/rtl/dtm_ctrl.sv
hw/rtl/dtm_datapath.sv
hw/rtl/delayed_timetag_merger.sv
tb/testbench.sv
